FILE: rtl/sl1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sl1_pkg
// Shared constants for the streaming Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sl1_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int PIXEL_W      = 8;
	localparam int CFG_WIDTH_W  = 12;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;
	localparam int CENTER_COL_W = 11;
	localparam int CENTER_ROW_W = 12;

	// gradient sums span -1020..1020
	localparam int GRAD_W = 11;

	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [PIXEL_W-1:0] MAG_MAX = 8'd255;

endpackage

FILE: rtl/sl1_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sl1_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sl1_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/sobel_l1_edge_magnitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_l1_edge_magnitude
// Streaming 3x3 Sobel edge detector with halved, saturated L1 magnitude.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order unless the output stalls, and
// gives one result per interior pixel in the cycle after its window
// completes. The rate is set by the line buffer: a single RAM holding both
// previous rows side by side, whose registered read is issued early at the
// column the next pixel will land on, so each pixel needs just one read and
// one write. Border pixels give no result. The line buffer is not cleared
// after reset; the first two rows of the first frame fill it before any of
// its contents reach a result. image_width and image_height are clamped to
// 3..MAX_WIDTH and 3..MAX_HEIGHT and should be written only while idle.
module sobel_l1_edge_magnitude #(
	parameter int MAX_WIDTH  = sl1_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sl1_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sl1_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sl1_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [sl1_pkg::PIXEL_W-1:0]      pixel,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sl1_pkg::PIXEL_W-1:0]      magnitude,
	output logic [sl1_pkg::CENTER_COL_W-1:0] center_col,
	output logic [sl1_pkg::CENTER_ROW_W-1:0] center_row,
	output logic                             last
);

	import sl1_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WWV = $clog2(MAX_WIDTH + 1);
	localparam int HWV = $clog2(MAX_HEIGHT + 1);
	localparam int LW  = (WWV > CFG_WIDTH_W) ? WWV : CFG_WIDTH_W;
	localparam int LH  = (HWV > CFG_HEIGHT_W) ? HWV : CFG_HEIGHT_W;

	function automatic logic signed [GRAD_W-1:0] ext(input logic [PIXEL_W-1:0] v);
		ext = $signed({{(GRAD_W-PIXEL_W){1'b0}}, v});
	endfunction

	function automatic logic [GRAD_W-2:0] absv(input logic signed [GRAD_W-1:0] v);
		logic signed [GRAD_W-1:0] n;
		n    = -v;
		absv = v[GRAD_W-1] ? n[GRAD_W-2:0] : v[GRAD_W-2:0];
	endfunction

	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;
	logic [PIXEL_W-1:0]      win_q [9];
	logic [CW-1:0]           col_q;
	logic [RW-1:0]           row_q;

	logic                    valid_s1;
	logic [PIXEL_W-1:0]      mag_s1;
	logic [CENTER_COL_W-1:0] ccol_s1;
	logic [CENTER_ROW_W-1:0] crow_s1;
	logic                    last_s1;

	logic                    in_fire;
	logic [LW-1:0]           w_raw, w_eff;
	logic [LH-1:0]           h_raw, h_eff;
	logic                    end_col, end_row, interior;
	logic [CW-1:0]           col_next, raddr;
	logic [RW-1:0]           row_next;
	logic [2*PIXEL_W-1:0]    rdata;
	logic [PIXEL_W-1:0]      top, mid;
	logic [PIXEL_W-1:0]      win_d [9];
	logic signed [GRAD_W-1:0] gx, gy;
	logic [GRAD_W-1:0]       l1;
	logic [GRAD_W-2:0]       half;
	logic [PIXEL_W-1:0]      mag_d;

	assign in_ready = !valid_s1 || out_ready;
	assign in_fire  = in_valid && in_ready;

	// effective frame size
	always_comb begin
		w_raw = LW'(width_q);
		h_raw = LH'(height_q);
		if (w_raw < LW'(3)) begin
			w_eff = LW'(3);
		end else if (w_raw > LW'(MAX_WIDTH)) begin
			w_eff = LW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw < LH'(3)) begin
			h_eff = LH'(3);
		end else if (h_raw > LH'(MAX_HEIGHT)) begin
			h_eff = LH'(MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
	end

	assign end_col  = (LW'(col_q) + LW'(1)) >= w_eff;
	assign end_row  = (LH'(row_q) + LH'(1)) >= h_eff;
	assign interior = (row_q >= RW'(2)) && (col_q >= CW'(2));

	always_comb begin
		if (end_col) begin
			col_next = '0;
			row_next = end_row ? '0 : row_q + 1'b1;
		end else begin
			col_next = col_q + 1'b1;
			row_next = row_q;
		end
	end

	// read ahead at the column the next item will take
	assign raddr = in_fire ? col_next : col_q;

	sl1_ram #(
		.WIDTH (2 * PIXEL_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (in_fire),
		.waddr (col_q),
		.wdata ({mid, pixel}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign top = rdata[2*PIXEL_W-1:PIXEL_W];
	assign mid = rdata[PIXEL_W-1:0];

	// shift the window left and insert the new column
	always_comb begin
		win_d[0] = win_q[1];
		win_d[1] = win_q[2];
		win_d[2] = top;
		win_d[3] = win_q[4];
		win_d[4] = win_q[5];
		win_d[5] = mid;
		win_d[6] = win_q[7];
		win_d[7] = win_q[8];
		win_d[8] = pixel;
	end

	always_comb begin
		gx = ((ext(win_d[5]) - ext(win_d[3])) <<< 1)
		   + (ext(win_d[2]) - ext(win_d[0]))
		   + (ext(win_d[8]) - ext(win_d[6]));
		gy = ((ext(win_d[1]) - ext(win_d[7])) <<< 1)
		   + (ext(win_d[2]) - ext(win_d[8]))
		   + (ext(win_d[0]) - ext(win_d[6]));
		l1   = {1'b0, absv(gx)} + {1'b0, absv(gy)};
		half = l1[GRAD_W-1:1];
		mag_d = (half > (GRAD_W-1)'(MAG_MAX)) ? MAG_MAX : half[PIXEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (in_fire) begin
			col_q <= col_next;
			row_q <= row_next;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= win_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= interior;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the payload until the next accepted item
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_s1  <= mag_d;
			ccol_s1 <= CENTER_COL_W'(col_q - 1'b1);
			crow_s1 <= CENTER_ROW_W'(row_q - 1'b1);
			last_s1 <= end_col && end_row;
		end
	end

	assign out_valid  = valid_s1;
	assign magnitude  = mag_s1;
	assign center_col = ccol_s1;
	assign center_row = crow_s1;
	assign last       = last_s1;

endmodule

FILE: rtl/sl1_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sl1_checker
// Port-level checks on the Sobel edge magnitude block, bound to the top level.
// ----------------------------------------------------------------------------
module sl1_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [sl1_pkg::PIXEL_W-1:0]      magnitude,
	input logic [sl1_pkg::CENTER_COL_W-1:0] center_col,
	input logic [sl1_pkg::CENTER_ROW_W-1:0] center_row,
	input logic                             last
);

	import sl1_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(magnitude)
			&& $stable(center_col) && $stable(center_row) && $stable(last))
		else $error("result changed while stalled");

	// an empty output register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// drop no result: a stalled result blocks new items
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// a result appears only after an accepted item
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without an accepted item");

endmodule

bind sobel_l1_edge_magnitude sl1_checker u_sl1_checker (.*);
